// ===== rtl/core/smzpd_pkg.sv =====
`default_nettype none

package smzpd_pkg;

  localparam int LEN_W  = 8;
  localparam int THR_W  = 8;
  localparam int INFL_W = 9;
  localparam int CFG_W  = 9;
  localparam int IDX_W  = 2;

  // influence of 1.0 in Q1.8
  localparam logic [INFL_W-1:0] INFL_ONE = 9'd256;
  localparam logic [LEN_W-1:0]  LEN_MIN  = 8'd2;

  localparam logic [LEN_W-1:0]  LEN_RESET  = 8'd100;
  localparam logic [THR_W-1:0]  THR_RESET  = 8'd80;
  localparam logic [INFL_W-1:0] INFL_RESET = 9'd0;

  typedef enum logic [IDX_W-1:0] {
    REG_WINDOW_LENGTH = 2'd0,
    REG_THRESHOLD     = 2'd1,
    REG_INFLUENCE     = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQR,
    ST_UPD
  } state_t;

  localparam logic [1:0] PEAK_NONE = 2'b00;
  localparam logic [1:0] PEAK_POS  = 2'b01;
  localparam logic [1:0] PEAK_NEG  = 2'b11;

endpackage

`default_nettype wire

// ===== rtl/core/smoothed_zscore_peak_detector_core.sv =====
// smoothed z-score peak detector
//
// input channel: sample with in_valid / in_ready. output channel: peak and
// stats_ready with out_valid / out_ready, one result per request.
// configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge (0 window_length, 1 threshold, 2 influence); no wait states. writing
// window_length clears the statistics and restarts warm-up.
//
// each request passes through the accept, difference, squaring and update
// steps: the accept cycle reads the ring entry to be evicted and forms the
// first products, then difference, squaring and the compare plus ring
// write-back follow. one request is in flight at a time, so a new sample is
// taken only after the last one has left its update step; the chain of
// products through the single-port ring read-modify-write is the reason.
// a result waits in the output register while the next request is taken;
// if it is still waiting when the next one finishes, the block holds in its
// last step until out_ready.
// reset (rst, synchronous) restores the register defaults, empties the
// statistics and drops out_valid. ring contents are not cleared: warm-up
// guarantees every entry is written before it is read.
`default_nettype none

module smoothed_zscore_peak_detector_core
  import smzpd_pkg::*;
#(
  parameter int MAX_WINDOW  = 128,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [IDX_W-1:0]              cfg_index,
  input  wire logic [CFG_W-1:0]              cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [1:0]                  peak,
  output logic                               stats_ready
);

  localparam int SB  = SAMPLE_BITS;
  localparam int PW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SW  = SB + $clog2(MAX_WINDOW) + 1;      // running sum, signed
  localparam int QW  = 2 * SB + $clog2(MAX_WINDOW);      // square sum, unsigned
  localparam int DW  = SW + 1;                           // L*y - S, signed
  localparam int LYW = LEN_W + 1 + SB;
  localparam int VW  = LEN_W + QW + 1;                   // L*Q - S^2, signed
  localparam int LHW = 2 * DW + 8;
  localparam int RHW = 2 * THR_W + VW - 1;
  localparam int CW  = (LHW > RHW) ? LHW + 1 : RHW + 1;
  localparam int MXW = SB + INFL_W + 2;
  localparam int PSW = 2 * SB;

  // configuration registers
  logic [LEN_W-1:0]  window_length;
  logic [THR_W-1:0]  threshold;
  logic [INFL_W-1:0] influence;

  // statistics
  logic signed [SW-1:0] running_sum;
  logic [QW-1:0]        running_square_sum;
  logic [LEN_W-1:0]     fill_count;
  logic [PW-1:0]        write_pointer;
  logic signed [SB-1:0] last_filtered;

  logic [SB-1:0] window_ring [MAX_WINDOW];
  logic [SB-1:0] ring_rd;

  state_t state, state_next;

  // pipeline registers
  logic signed [SB-1:0]  y;
  logic                  full;
  logic signed [LYW-1:0] ly;
  logic [LEN_W+QW-1:0]   lq;
  logic signed [2*SW-1:0] ss;
  logic [2*THR_W-1:0]    thr2;
  logic [DW-1:0]         ad;
  logic                  d_pos;
  logic [VW-2:0]         uvar;
  logic signed [SB-1:0]  mixf;
  logic [2*DW-1:0]       ad2;
  logic [RHW-1:0]        rhs;
  logic [PSW-1:0]        ysq;
  logic [PSW-1:0]        msq;
  logic [PSW-1:0]        osq;

  logic [LEN_W-1:0]      len;
  logic [INFL_W-1:0]     w_sat;
  logic                  accept;
  logic                  upd_go;

  logic                  flag;
  logic signed [SB-1:0]  filt;
  logic [PW:0]           ptr_inc;

  always_comb begin
    if (window_length < LEN_MIN) begin
      len = LEN_MIN;
    end else if (int'(window_length) > MAX_WINDOW) begin
      len = LEN_W'(MAX_WINDOW);
    end else begin
      len = window_length;
    end
    w_sat = (influence > INFL_ONE) ? INFL_ONE : influence;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: state_next = ST_SQR;
      ST_SQR:  state_next = ST_UPD;
      ST_UPD: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready = 1'b0;
    upd_go   = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_UPD:  upd_go   = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ring memory: read the entry to evict on accept, write back on update
  always_ff @(posedge clk) begin
    if (accept) begin
      ring_rd <= window_ring[write_pointer];
    end
    if (upd_go) begin
      window_ring[write_pointer] <= filt;
    end
  end

  // accept stage: first products
  always_ff @(posedge clk) begin
    if (accept) begin
      y    <= sample;
      full <= fill_count >= len;
      ly   <= $signed({1'b0, len}) * sample;
      lq   <= len * running_square_sum;
      ss   <= running_sum * running_sum;
      thr2 <= threshold * threshold;
    end
  end

  // difference stage
  logic signed [DW-1:0]  d_c;
  logic signed [VW-1:0]  var_c;
  logic signed [MXW-1:0] mix_c;

  always_comb begin
    d_c   = DW'(ly) - DW'(running_sum);
    var_c = $signed({1'b0, lq}) - VW'(ss);
    mix_c = MXW'($signed({1'b0, w_sat}) * y)
          + MXW'($signed({1'b0, INFL_ONE - w_sat}) * last_filtered);
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIFF) begin
      ad    <= d_c[DW-1] ? DW'(-d_c) : DW'(d_c);
      d_pos <= !d_c[DW-1] && (d_c != '0);
      uvar  <= var_c[VW-1] ? '0 : var_c[VW-2:0];
      // arithmetic shift gives floor division by 256
      mixf  <= mix_c[SB+7:8];
    end
  end

  // squaring stage
  logic signed [SB-1:0] old_s;
  assign old_s = $signed(ring_rd);

  always_ff @(posedge clk) begin
    if (state == ST_SQR) begin
      ad2 <= ad * ad;
      rhs <= thr2 * uvar;
      ysq <= PSW'(y * y);
      msq <= PSW'(mixf * mixf);
      osq <= PSW'(old_s * old_s);
    end
  end

  // update stage
  always_comb begin
    flag    = full && ({ad2, 8'd0} > CW'(rhs));
    filt    = flag ? mixf : y;
    ptr_inc = {1'b0, write_pointer} + (PW + 1)'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length      <= LEN_RESET;
      threshold          <= THR_RESET;
      influence          <= INFL_RESET;
      running_sum        <= '0;
      running_square_sum <= '0;
      fill_count         <= '0;
      write_pointer      <= '0;
      last_filtered      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_LENGTH: begin
            window_length      <= cfg_data[LEN_W-1:0];
            running_sum        <= '0;
            running_square_sum <= '0;
            fill_count         <= '0;
            write_pointer      <= '0;
            last_filtered      <= '0;
          end
          REG_THRESHOLD: threshold <= cfg_data[THR_W-1:0];
          REG_INFLUENCE: influence <= cfg_data[INFL_W-1:0];
          default: begin
          end
        endcase
      end
      if (upd_go) begin
        if (full) begin
          running_sum        <= running_sum - SW'(old_s) + SW'(filt);
          running_square_sum <= running_square_sum - QW'(osq)
                              + QW'(flag ? msq : ysq);
        end else begin
          running_sum        <= running_sum + SW'(filt);
          running_square_sum <= running_square_sum + QW'(ysq);
          fill_count         <= fill_count + LEN_W'(1);
        end
        if (32'(ptr_inc) >= 32'(len)) begin
          write_pointer <= '0;
        end else begin
          write_pointer <= ptr_inc[PW-1:0];
        end
        last_filtered <= filt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      peak        <= !flag ? PEAK_NONE : (d_pos ? PEAK_POS : PEAK_NEG);
      stats_ready <= full;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= len)
    else $error("fill count beyond window length");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    32'(write_pointer) < 32'(len))
    else $error("write pointer outside window");

  a_warmup_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !stats_ready |-> peak == PEAK_NONE)
    else $error("peak reported during warm-up");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_DIFF)
    else $error("accepted request did not start processing");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import smzpd_pkg::*;

  localparam int MAX_WIN      = 128;
  localparam int LATENCY      = 4;
  localparam int RANDOM_ITEMS = 1875;
  localparam int HOLD_AT      = 600;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DIR_N        = 26;

  typedef struct packed {
    logic [1:0] peak;
    logic       stats_ready;
  } peak_result_t;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_reg_t    idx;
    logic [15:0] value;
    logic        typed;
    logic [1:0]  peak;
    logic        stats_ready;
  } dir_row_t;

  typedef enum logic [1:0] {MODE_NOISE, MODE_FLAT, MODE_WILD} stim_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  cfg_reg_t cfg_index = REG_WINDOW_LENGTH;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [1:0] peak;
  logic stats_ready;

  smoothed_zscore_peak_detector_core #(
    .MAX_WINDOW (MAX_WIN),
    .SAMPLE_BITS(16)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .peak       (peak),
    .stats_ready(stats_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: configuration and window statistics
  int cfg_len;
  int cfg_thr;
  int cfg_infl;
  logic signed [15:0] hist_ring [0:MAX_WIN-1];
  longint win_sum;
  longint win_sqsum;
  int fill_cnt;
  int wptr;
  logic signed [15:0] last_filt;

  peak_result_t expected_q [$];
  peak_result_t exp_r;
  int err_count = 0;
  int rx_stall = 0;
  int cycles = 0;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  dir_row_t dir_rows [DIR_N] = '{
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h8000, 1'b1, PEAK_NONE, 1'b0},
    '{ROW_CFG,    REG_WINDOW_LENGTH, 16'h0000, 1'b0, PEAK_NONE, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h0005, 1'b1, PEAK_NONE, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h0005, 1'b1, PEAK_NONE, 1'b0},
    // flat window, sample equal to the mean
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h0005, 1'b1, PEAK_NONE, 1'b1},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h0006, 1'b1, PEAK_POS,  1'b1},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h0004, 1'b1, PEAK_NEG,  1'b1},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h7fff, 1'b1, PEAK_POS,  1'b1},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h8000, 1'b1, PEAK_NEG,  1'b1},
    '{ROW_CFG,    REG_INFLUENCE,     16'h01ff, 1'b0, PEAK_NONE, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h7fff, 1'b1, PEAK_POS,  1'b1},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h8000, 1'b0, PEAK_NONE, 1'b0},
    '{ROW_CFG,    REG_THRESHOLD,     16'h0000, 1'b0, PEAK_NONE, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h0000, 1'b0, PEAK_NONE, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h7fff, 1'b0, PEAK_NONE, 1'b0},
    '{ROW_CFG,    REG_THRESHOLD,     16'h00ff, 1'b0, PEAK_NONE, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h8000, 1'b0, PEAK_NONE, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h0001, 1'b0, PEAK_NONE, 1'b0},
    '{ROW_CFG,    REG_WINDOW_LENGTH, 16'h0001, 1'b0, PEAK_NONE, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'hffff, 1'b1, PEAK_NONE, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h0001, 1'b1, PEAK_NONE, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h0000, 1'b1, PEAK_NONE, 1'b1},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h8000, 1'b0, PEAK_NONE, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h7fff, 1'b0, PEAK_NONE, 1'b0},
    '{ROW_CFG,    REG_WINDOW_LENGTH, 16'h00ff, 1'b0, PEAK_NONE, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h0007, 1'b1, PEAK_NONE, 1'b0}
  };

  function automatic int eff_window(input int len);
    if (len < 2) return 2;
    if (len > MAX_WIN) return MAX_WIN;
    return len;
  endfunction

  function automatic void clear_statistics();
    win_sum = 0;
    win_sqsum = 0;
    fill_cnt = 0;
    wptr = 0;
    last_filt = '0;
  endfunction

  // one step of the detector: z-score test, blend on a peak, window update
  function automatic void detector_step(input logic signed [15:0] y,
                                        output peak_result_t res);
    int len;
    int w;
    longint d;
    longint ad;
    longint spread;
    longint lhs;
    longint rhs;
    longint mix;
    logic signed [15:0] filt;
    logic signed [15:0] old;
    len = eff_window(cfg_len);
    filt = y;
    res.peak = PEAK_NONE;
    res.stats_ready = (fill_cnt >= len);
    if (res.stats_ready) begin
      d = longint'(len) * y - win_sum;
      ad = (d < 0) ? -d : d;
      spread = longint'(len) * win_sqsum - win_sum * win_sum;
      if (spread < 0) spread = 0;
      lhs = ad * ad * 256;
      rhs = longint'(cfg_thr) * longint'(cfg_thr) * spread;
      if (lhs > rhs) begin
        w = (cfg_infl > 256) ? 256 : cfg_infl;
        mix = longint'(w) * y + longint'(256 - w) * last_filt;
        filt = 16'(mix >>> 8);
        res.peak = (d > 0) ? PEAK_POS : PEAK_NEG;
      end
      old = hist_ring[wptr];
      win_sum -= old;
      win_sqsum -= longint'(old) * old;
    end else begin
      fill_cnt++;
    end
    hist_ring[wptr] = filt;
    win_sum += filt;
    win_sqsum += longint'(filt) * filt;
    wptr++;
    if (wptr >= len) wptr = 0;
    last_filt = filt;
  endfunction

  function automatic logic signed [15:0] next_sample(input stim_mode_t mode,
                                                     input int base, input int amp);
    int v;
    v = base;
    case (mode)
      MODE_NOISE: v = base + int'($urandom_range(0, 2 * amp)) - amp;
      MODE_FLAT: begin
        if ($urandom_range(0, 7) == 0) v = base + int'($urandom_range(0, 6)) - 3;
      end
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    // occasional spike on top of the baseline
    if (mode != MODE_WILD && $urandom_range(0, 11) == 0) begin
      if ($urandom_range(0, 1) == 1) v = v + int'($urandom_range(1, 40000));
      else v = v - int'($urandom_range(1, 40000));
    end
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic send_sample(input logic signed [15:0] s, input logic typed,
                             input logic [1:0] t_peak, input logic t_ready);
    int gap;
    peak_result_t res;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    detector_step(s, res);
    if (typed) begin
      res.peak = t_peak;
      res.stats_ready = t_ready;
    end
    expected_q.push_back(res);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_WINDOW_LENGTH: begin
        cfg_len = int'(val & 'hff);
        clear_statistics();
      end
      REG_THRESHOLD: cfg_thr = int'(val & 'hff);
      REG_INFLUENCE: cfg_infl = int'(val & 'h1ff);
      default: ;
    endcase
  endtask

  // result side: check against the oldest expectation, random stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: peak=%b stats_ready=%b", peak, stats_ready);
          err_count++;
        end else begin
          exp_r = expected_q.pop_front();
          if (peak !== exp_r.peak) begin
            $error("peak: expected %b, got %b", exp_r.peak, peak);
            err_count++;
          end
          if (stats_ready !== exp_r.stats_ready) begin
            $error("stats_ready: expected %b, got %b", exp_r.stats_ready, stats_ready);
            err_count++;
          end
        end
        rx_stall = no_gaps ? 0 : $urandom_range(0, 9);
      end else if (rx_stall > 0) begin
        rx_stall--;
      end
      // long hold-off so the block backs up into its input
      if (hold_req) begin
        rx_stall = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      out_ready <= (rx_stall == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("** smoothed_zscore_peak_detector_core: FAILED **");
      $finish;
    end
  end

  initial begin
    int n_random;
    int n_phase;
    int pick;
    int len;
    int base;
    int amp;
    stim_mode_t mode;
    cfg_len = int'(LEN_RESET);
    cfg_thr = int'(THR_RESET);
    cfg_infl = int'(INFL_RESET);
    clear_statistics();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(dir_rows[i].idx, 32'(dir_rows[i].value));
      end else begin
        send_sample(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].peak,
                    dir_rows[i].stats_ready);
      end
    end

    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      drain_results();
      n_phase = $urandom_range(20, 60);
      // mostly restart the window, sometimes keep the statistics running
      if ($urandom_range(0, 9) < 7) begin
        pick = $urandom_range(0, 19);
        if (pick < 13) len = $urandom_range(2, 16);
        else if (pick < 16) len = $urandom_range(17, 64);
        else if (pick == 16) len = MAX_WIN;
        else if (pick == 17) len = $urandom_range(0, 1);
        else if (pick == 18) len = $urandom_range(129, 255);
        else len = MAX_WIN - 1;
        write_reg(REG_WINDOW_LENGTH, len);
        n_phase = eff_window(len) + $urandom_range(10, 60);
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) write_reg(REG_THRESHOLD, 0);
      else if (pick == 1) write_reg(REG_THRESHOLD, 255);
      else if (pick < 4) write_reg(REG_THRESHOLD, $urandom_range(0, 255));
      else write_reg(REG_THRESHOLD, $urandom_range(16, 64));
      pick = $urandom_range(0, 7);
      if (pick == 0) write_reg(REG_INFLUENCE, 0);
      else if (pick == 1) write_reg(REG_INFLUENCE, 32'(INFL_ONE));
      else if (pick == 2) write_reg(REG_INFLUENCE, 511);
      else write_reg(REG_INFLUENCE, $urandom_range(0, 511));

      no_gaps = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 9);
      mode = (pick < 6) ? MODE_NOISE : (pick < 8) ? MODE_FLAT : MODE_WILD;
      pick = $urandom_range(0, 9);
      if (pick == 0) base = $urandom_range(32000, 32767);
      else if (pick == 1) base = -int'($urandom_range(32000, 32768));
      else base = int'($urandom_range(0, 16000)) - 8000;
      amp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 3000);

      // receiver holds off at the start of a full phase of requests
      if (!hold_done && n_random >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_req = 1'b1;
      end

      for (int k = 0; k < n_phase; k++) begin
        send_sample(next_sample(mode, base, amp), 1'b0, PEAK_NONE, 1'b0);
        n_random++;
      end
    end

    no_gaps = 1'b0;
    drain_results();
    repeat (2 * LATENCY) @(posedge clk);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("** smoothed_zscore_peak_detector_core: PASSED **");
    end else begin
      $display("** smoothed_zscore_peak_detector_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
